[src/assert_macros.svh]
// Assertion helpers for the go-back-n sender checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, sampled on the rising clock edge, muted in reset.
`define GBN_ASSERT_NOW(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the trigger.
`define GBN_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[src/gbn_pkg.sv]
package gbn_pkg;

    // Fixed field widths
    localparam int PAYLOAD_W = 64;
    localparam int SEQ_W     = 8;
    localparam int KIND_W    = 2;
    localparam int TMR_W     = 2;
    localparam int WIN_W     = 5;
    localparam int SBITS_W   = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int P_MAX_WINDOW   = 16;
    localparam int P_DATA_BITS    = 64;
    localparam int P_MAX_SEQ_BITS = 8;

    // Reset values of the configuration registers
    localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(4);
    localparam logic [SBITS_W-1:0] SBITS_RST  = SBITS_W'(8);
    localparam logic [SBITS_W-1:0] SBITS_MIN  = SBITS_W'(4);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS    = 1'b1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    // Timer commands
    localparam logic [TMR_W-1:0] TMR_LEAVE = 2'd0;
    localparam logic [TMR_W-1:0] TMR_START = 2'd1;
    localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

    // Effective sequence configuration, sized for the widest sequence space
    typedef struct packed {
        logic [SEQ_W-1:0] mask;
        logic [SEQ_W-1:0] win;
    } t_seq_cfg;

endpackage

[src/gbn_in_if.sv]
interface gbn_in_if import gbn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     ack_number;
    logic                 ack_intact;

    modport source (output valid, kind, payload, ack_number, ack_intact, input ready);
    modport sink   (input valid, kind, payload, ack_number, ack_intact, output ready);
endinterface

[src/gbn_out_if.sv]
interface gbn_out_if import gbn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 packet_valid;
    logic [SEQ_W-1:0]     packet_seq;
    logic [PAYLOAD_W-1:0] packet_data;
    logic                 send_accepted;
    logic [TMR_W-1:0]     timer_command;
    logic                 last;

    modport source (output valid, packet_valid, packet_seq, packet_data, send_accepted,
                    timer_command, last, input ready);
    modport sink   (input valid, packet_valid, packet_seq, packet_data, send_accepted,
                    timer_command, last, output ready);
endinterface

[src/gbn_store.sv]
module gbn_store #(
    parameter int AW = 4,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[src/gbn_ctrl.sv]
module gbn_ctrl import gbn_pkg::*; #(
    parameter int MAX_WINDOW   = P_MAX_WINDOW,
    parameter int DATA_BITS    = P_DATA_BITS,
    parameter int MAX_SEQ_BITS = P_MAX_SEQ_BITS,
    parameter int SLOT_AW      = $clog2(MAX_WINDOW + 1) - 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_seq_cfg             i_cfg,
    gbn_in_if.sink               i_in,
    gbn_out_if.source            o_out,
    output logic                 o_mem_we,
    output logic [SLOT_AW-1:0]   o_mem_waddr,
    output logic [DATA_BITS-1:0] o_mem_wdata,
    output logic                 o_mem_re,
    output logic [SLOT_AW-1:0]   o_mem_raddr,
    input  logic [DATA_BITS-1:0] i_mem_rdata
);

    localparam int SLOTS = 1 << SLOT_AW;
    localparam int LW    = SLOT_AW + 1;
    localparam int CW    = (MAX_SEQ_BITS > LW) ? MAX_SEQ_BITS : LW;
    localparam int SW    = MAX_SEQ_BITS;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    logic                 r_state,     n_state;
    logic [SW-1:0]        r_base,      n_base;
    logic [SW-1:0]        r_next,      n_next;
    logic [SW-1:0]        r_resend_ptr, n_resend_ptr;
    logic [LW-1:0]        r_left,      n_left;
    logic                 r_out_valid, n_out_valid;
    logic                 r_pkt_valid, n_pkt_valid;
    logic [SW-1:0]        r_pkt_seq,   n_pkt_seq;
    logic [DATA_BITS-1:0] r_pkt_data,  n_pkt_data;
    logic                 r_from_mem,  n_from_mem;
    logic                 r_acc,       n_acc;
    logic [TMR_W-1:0]     r_timer,     n_timer;
    logic                 r_last,      n_last;

    logic          out_free;
    logic          in_acc;
    logic          fin;
    logic [SW-1:0] mask;
    logic [SW-1:0] win;
    logic [SW-1:0] base;
    logic [SW-1:0] next;
    logic [SW-1:0] count;
    logic [SW-1:0] ack;
    logic [SW-1:0] ack_off;
    logic [SW-1:0] ack_base;
    logic [CW-1:0] count_w;

    // Sequence arithmetic in the current sequence space
    assign mask     = i_cfg.mask[SW-1:0];
    assign win      = i_cfg.win[SW-1:0];
    assign base     = r_base & mask;
    assign next     = r_next & mask;
    assign count    = (next - base) & mask;
    assign ack      = i_in.ack_number[SW-1:0] & mask;
    assign ack_off  = (ack - base) & mask;
    assign ack_base = (ack + SW'(1)) & mask;
    assign count_w  = CW'(count);
    assign fin      = (r_left == LW'(1));

    // Output register frees when empty or drained this cycle
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;

    // Store access: writes only on sends, reads only during replay
    assign o_mem_waddr = SLOT_AW'(next);
    assign o_mem_wdata = i_in.payload[DATA_BITS-1:0];
    assign o_mem_raddr = SLOT_AW'(r_resend_ptr);

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_next       = r_next;
        n_resend_ptr = r_resend_ptr;
        n_left       = r_left;
        n_out_valid  = r_out_valid;
        n_pkt_valid  = r_pkt_valid;
        n_pkt_seq    = r_pkt_seq;
        n_pkt_data   = r_pkt_data;
        n_from_mem   = r_from_mem;
        n_acc        = r_acc;
        n_timer      = r_timer;
        n_last       = r_last;
        o_mem_we     = 1'b0;
        o_mem_re     = 1'b0;

        // Drop the result once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // Default single result: nothing but last
                    n_out_valid = 1'b1;
                    n_pkt_valid = 1'b0;
                    n_pkt_seq   = '0;
                    n_pkt_data  = '0;
                    n_from_mem  = 1'b0;
                    n_acc       = 1'b0;
                    n_timer     = TMR_LEAVE;
                    n_last      = 1'b1;
                    case (i_in.kind)
                        KIND_SEND: begin
                            if (count < win) begin
                                o_mem_we    = 1'b1;
                                n_pkt_valid = 1'b1;
                                n_pkt_seq   = next;
                                n_pkt_data  = i_in.payload[DATA_BITS-1:0];
                                n_acc       = 1'b1;
                                n_timer     = (count == '0) ? TMR_START : TMR_LEAVE;
                                n_next      = (next + SW'(1)) & mask;
                                n_base      = base;
                            end
                        end
                        KIND_ACK: begin
                            if (i_in.ack_intact && (ack_off < count)) begin
                                n_base  = ack_base;
                                n_next  = next;
                                n_timer = (ack_base != next) ? TMR_START : TMR_STOP;
                            end
                        end
                        KIND_TIMEOUT: begin
                            if (count == '0) begin
                                n_timer = TMR_STOP;
                            end else begin
                                // Hand over to the replay sequencer
                                n_out_valid  = 1'b0;
                                n_state      = ST_REPLAY;
                                n_resend_ptr = base;
                                n_left       = (count_w > CW'(SLOTS)) ? LW'(SLOTS)
                                                                      : LW'(count_w);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REPLAY: begin
                // Read one slot per free output slot; data lands with the result
                if (out_free) begin
                    o_mem_re     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pkt_valid  = 1'b1;
                    n_pkt_seq    = r_resend_ptr;
                    n_pkt_data   = '0;
                    n_from_mem   = 1'b1;
                    n_acc        = 1'b0;
                    n_timer      = fin ? TMR_START : TMR_LEAVE;
                    n_last       = fin;
                    n_resend_ptr = (r_resend_ptr + SW'(1)) & mask;
                    n_left       = r_left - LW'(1);
                    if (fin) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_base       <= '0;
            r_next       <= '0;
            r_resend_ptr <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_base       <= n_base;
            r_next       <= n_next;
            r_resend_ptr <= n_resend_ptr;
            r_left       <= n_left;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_pkt_valid <= n_pkt_valid;
        r_pkt_seq   <= n_pkt_seq;
        r_pkt_data  <= n_pkt_data;
        r_from_mem  <= n_from_mem;
        r_acc       <= n_acc;
        r_timer     <= n_timer;
        r_last      <= n_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.packet_valid  = r_pkt_valid;
    assign o_out.packet_seq    = SEQ_W'(r_pkt_seq);
    assign o_out.packet_data   = PAYLOAD_W'(r_from_mem ? i_mem_rdata : r_pkt_data);
    assign o_out.send_accepted = r_acc;
    assign o_out.timer_command = r_timer;
    assign o_out.last          = r_last;

endmodule

[src/go_back_n_sender.sv]
// Channel  Dir  Modport  Carries
// i_in     in   sink     kind, payload, ack_number, ack_intact
// o_out    out  source   packet_valid, packet_seq, packet_data, send_accepted,
//                        timer_command, last
// i_cfg_*  in   -        window_size (index 0), seq_bits (index 1)
//
// Sends, acknowledgments and idle timeouts each give a single result.
// A timeout with packets outstanding replays them one packet per cycle while the
// output is not stalled, paced by the single read port of the payload store.
// Synchronous reset clears the window pointers and restores the configuration
// defaults; the payload store has no clearing pass and is undefined until written.
// A stalled output holds its result and input stays refused until it drains.
module go_back_n_sender import gbn_pkg::*; #(
    parameter int MAX_WINDOW   = P_MAX_WINDOW,
    parameter int DATA_BITS    = P_DATA_BITS,
    parameter int MAX_SEQ_BITS = P_MAX_SEQ_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gbn_in_if.sink               i_in,
    gbn_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int SLOT_AW = $clog2(MAX_WINDOW + 1) - 1;
    localparam int SLOTS   = 1 << SLOT_AW;

    logic [WIN_W-1:0]   r_window_size;
    logic [SBITS_W-1:0] r_seq_bits;

    logic [SBITS_W-1:0]   sbits;
    logic [SEQ_W:0]       mask_w;
    logic [SEQ_W:0]       win_w;
    t_seq_cfg             seq_cfg;
    logic                 mem_we;
    logic [SLOT_AW-1:0]   mem_waddr;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [SLOT_AW-1:0]   mem_raddr;
    logic [DATA_BITS-1:0] mem_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RST;
            r_seq_bits    <= SBITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_wdata[WIN_W-1:0];
                CFG_SEQ_BITS:    r_seq_bits    <= i_cfg_wdata[SBITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp sequence width and window into the supported range
    always_comb begin
        if (r_seq_bits < SBITS_MIN) begin
            sbits = SBITS_MIN;
        end else if (r_seq_bits > SBITS_W'(MAX_SEQ_BITS)) begin
            sbits = SBITS_W'(MAX_SEQ_BITS);
        end else begin
            sbits = r_seq_bits;
        end
        mask_w = ((SEQ_W + 1)'(1) << sbits) - (SEQ_W + 1)'(1);

        win_w = (SEQ_W + 1)'(r_window_size);
        if (win_w > (SEQ_W + 1)'(SLOTS)) begin
            win_w = (SEQ_W + 1)'(SLOTS);
        end
        if (win_w > mask_w) begin
            win_w = mask_w;
        end
        if (win_w == '0) begin
            win_w = (SEQ_W + 1)'(1);
        end
    end

    assign seq_cfg.mask = mask_w[SEQ_W-1:0];
    assign seq_cfg.win  = win_w[SEQ_W-1:0];

    gbn_ctrl #(
        .MAX_WINDOW   (MAX_WINDOW),
        .DATA_BITS    (DATA_BITS),
        .MAX_SEQ_BITS (MAX_SEQ_BITS),
        .SLOT_AW      (SLOT_AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (seq_cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    gbn_store #(
        .AW (SLOT_AW),
        .DW (DATA_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

[src/gbn_chk.sv]
`include "assert_macros.svh"

module gbn_chk import gbn_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_packet_valid,
    input logic             i_send_accepted,
    input logic [TMR_W-1:0] i_timer_command,
    input logic             i_last
);

    // Hold a stalled result
    `GBN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // An accepted send is a single packet result
    `GBN_ASSERT_NOW(a_send_single, i_clk, i_rst_n, i_out_valid && i_send_accepted, i_packet_valid && i_last, "accepted send without packet or last")

    // Only replay packets precede the final result
    `GBN_ASSERT_NOW(a_mid_replay, i_clk, i_rst_n, i_out_valid && !i_last, i_packet_valid && !i_send_accepted && (i_timer_command == TMR_LEAVE), "non-final result is not a plain replay packet")

    // Replay restarts the timer exactly on its final packet
    `GBN_ASSERT_NOW(a_replay_timer, i_clk, i_rst_n, i_out_valid && i_packet_valid && !i_send_accepted, i_last == (i_timer_command == TMR_START), "replay timer command out of place")

    // Refuse new requests while a replay is still running
    `GBN_ASSERT_NOW(a_replay_busy, i_clk, i_rst_n, i_out_valid && !i_last, !i_in_ready, "request open in the middle of a replay")

endmodule

bind go_back_n_sender gbn_chk u_gbn_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_packet_valid  (o_out.packet_valid),
    .i_send_accepted (o_out.send_accepted),
    .i_timer_command (o_out.timer_command),
    .i_last          (o_out.last)
);
